// ===== src/l0pps_pkg.sv =====
// Package for the profile pair shift optimizer: shared widths, payload words,
// configuration register codes, sequencer states and the shared unit request.
// Used by every module in src.
package l0pps_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned DW             = 64;  // datapath width
  localparam int unsigned PFW            = 40;  // prefix curvature width
  localparam int unsigned DVW            = 7;   // divisor width, holds a ring size
  localparam int unsigned QW             = 80;  // product accumulator width

  typedef logic signed [DW-1:0] dword_t;

  localparam dword_t DWORD_MAX = {1'b0, {(DW-1){1'b1}}};

  typedef struct packed {
    logic signed [31:0] curvature;
    logic [31:0]        beta;
    logic               last_point;
  } in_word_t;

  typedef struct packed {
    logic [31:0] beta_out;
    logic [5:0]  point_index;
    logic        last_out;
  } out_word_t;

  typedef enum logic [1:0] {
    CFG_LAMBDA     = 2'd0,
    CFG_MAX_VALUE  = 2'd1,
    CFG_MAX_ROUNDS = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_DIV,
    OP_QMUL
  } iter_op_e;

  typedef struct packed {
    logic     start;
    iter_op_e op;
  } iter_req_t;

  typedef enum logic {
    COST_INIT,
    COST_TRIAL
  } cost_mode_e;

  typedef enum logic [5:0] {
    S_LOAD, S_INIT, S_CRD, S_CT, S_CM, S_CA, S_CEND, S_RSTART,
    S_SPLIT, S_SP1, S_SP2, S_SP3, S_SP4, S_MRD, S_MUP, S_LH1, S_LH2,
    S_CAND0, S_CAND1, S_SLP1, S_SLP2, S_SLP3, S_KX, S_KY, S_KQ, S_KJ,
    S_CLAMP, S_DN1, S_DN2, S_NEXT, S_REND, S_ARD, S_AWR, S_CALL, S_WAIT,
    S_ORD, S_OVL, S_OHOLD
  } state_e;

endpackage

// ===== src/l0pps_iter.sv =====
// Shared bit-serial arithmetic unit: signed divide by a small positive
// divisor, truncating, and Q16.16 multiply of two signed words.
// Depends on l0pps_pkg.
module l0pps_iter import l0pps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  iter_req_t req_i,
  input  dword_t    a_i,
  input  dword_t    b_i,
  output logic      done_o,
  output dword_t    res_o
);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  iter_op_e       op_q, op_d;
  logic           neg_q, neg_d;
  logic [5:0]     cnt_q, cnt_d;
  logic [QW-1:0]  x_q, x_d;
  logic [DW-1:0]  y_q, y_d;
  logic [QW-1:0]  acc_q, acc_d;
  logic [DVW-1:0] rem_q, rem_d;
  logic [DVW-1:0] dv_q, dv_d;
  dword_t         res_q, res_d;

  logic [DW-1:0]  abs_a, abs_b;
  logic [DVW:0]   r2;
  logic           ge;
  logic [DW-1:0]  mag;

  assign abs_a = a_i[DW-1] ? DW'(-a_i) : DW'(a_i);
  assign abs_b = b_i[DW-1] ? DW'(-b_i) : DW'(b_i);
  assign r2    = {rem_q, x_q[DW-1]};
  assign ge    = (r2 >= {1'b0, dv_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    res_d  = res_q;
    mag    = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      neg_d  = (req_i.op == OP_DIV) ? a_i[DW-1] : (a_i[DW-1] != b_i[DW-1]);
      cnt_d  = '0;
      x_d    = {{(QW-DW){1'b0}}, abs_a};
      y_d    = abs_b;
      acc_d  = '0;
      rem_d  = '0;
      dv_d   = b_i[DVW-1:0];
    end else if (busy_q) begin
      cnt_d = cnt_q + 6'd1;
      if (op_q == OP_DIV) begin
        // Restoring division: one quotient bit per cycle, MSB first.
        rem_d = ge ? DVW'(r2 - {1'b0, dv_q}) : r2[DVW-1:0];
        x_d   = {x_q[QW-2:0], ge};
        mag   = x_d[DW-1:0];
      end else begin
        acc_d = y_q[0] ? acc_q + x_q : acc_q;
        x_d   = {x_q[QW-2:0], 1'b0};
        y_d   = {1'b0, y_q[DW-1:1]};
        mag   = acc_d[QW-1:16];
      end
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? dword_t'(-mag) : dword_t'(mag);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== src/l0pps_mem.sv =====
// Point stores: base beta, curvature and prefix curvature, one registered
// read port each (beta and curvature share an address). Depends on l0pps_pkg.
module l0pps_mem import l0pps_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  localparam int unsigned AW = $clog2(MAX_POINTS)
) (
  input  logic                  clk_i,
  input  logic                  ld_we_i,
  input  logic [AW-1:0]         ld_addr_i,
  input  logic signed [31:0]    ld_curv_i,
  input  logic signed [PFW-1:0] ld_pf_i,
  input  logic                  bb_we_i,
  input  logic [AW-1:0]         bb_waddr_i,
  input  logic [31:0]           bb_wdata_i,
  input  logic [AW-1:0]         rd_addr_i,
  input  logic [AW-1:0]         pf_addr_i,
  output logic [31:0]           bb_rdata_o,
  output logic signed [31:0]    cv_rdata_o,
  output logic signed [PFW-1:0] pf_rdata_o
);

  logic [31:0]           bb_mem [MAX_POINTS];
  logic signed [31:0]    cv_mem [MAX_POINTS];
  logic signed [PFW-1:0] pf_mem [MAX_POINTS];

  always_ff @(posedge clk_i) begin
    if (bb_we_i) begin
      bb_mem[bb_waddr_i] <= bb_wdata_i;
    end
    if (ld_we_i) begin
      cv_mem[ld_addr_i] <= ld_curv_i;
      pf_mem[ld_addr_i] <= ld_pf_i;
    end
    bb_rdata_o <= bb_mem[rd_addr_i];
    cv_rdata_o <= cv_mem[rd_addr_i];
    pf_rdata_o <= pf_mem[pf_addr_i];
  end

endmodule

// ===== src/l0_profile_pair_shift_optimizer.sv =====
// Loading takes one cycle per point. Optimization runs per round over all
// n(n-1)/2 splits; each split makes eighteen calls of the shared serial
// divide/multiply unit (64 steps plus issue and handoff) plus two memory
// scans, and a kept round adds a pass that rewrites the betas. Results leave
// one word at a time; the next word is read only after the last is taken.
// Reset clears control and config only; the point stores are not cleared
// and need no clearing pass.
module l0_profile_pair_shift_optimizer import l0pps_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  state_e     state_q, state_d, ret_q, ret_d;
  cost_mode_e mode_q, mode_d;

  logic [31:0]           lambda_q, lambda_d, maxv_q, maxv_d;
  logic [15:0]           maxr_q, maxr_d, rnd_q, rnd_d;
  logic [CW-1:0]         cnt_q, cnt_d, n1_q, n1_d, n2_q, n2_d, neq_q, neq_d;
  logic signed [PFW-1:0] run_q, run_d, pf1_q, pf1_d, r1_q, r1_d, r2_q, r2_d;
  logic [AW-1:0]         p1_q, p1_d, p2_q, p2_d, rb_p1_q, rb_p1_d, rb_p2_q, rb_p2_d;
  logic [AW-1:0]         i_q, i_d;
  logic [1:0]            k_q, k_d;
  logic [2*CW-1:0]       nn_q, nn_d;
  logic [31:0]           b_p2_q, b_p2_d, b_pv2_q, b_pv2_d, b_p1m_q, b_p1m_d;
  logic [31:0]           b_p1_q, b_p1_d;
  logic [31:0]           min1_q, min1_d, max1_q, max1_d, min2_q, min2_d, max2_q, max2_d;
  logic [31:0]           t_q, t_d, t0_q, t0_d, tprev_q, tprev_d;
  logic signed [31:0]    cv_q, cv_d;
  dword_t pa_q, pa_d, pb_q, pb_d, pc_q, pc_d, pd_q, pd_d;
  dword_t lo_q, lo_d, hi_q, hi_d, cand0_q, cand0_d, cand1_q, cand1_d;
  dword_t q1_q, q1_d, slope_q, slope_d, x_q, x_d, xa_q, xa_d, xb_q, xb_d;
  dword_t jbest_q, jbest_d, d_q, d_d, dn1_q, dn1_d, dn2_q, dn2_d;
  dword_t rb_dn1_q, rb_dn1_d, rb_dn2_q, rb_dn2_d;
  dword_t best_q, best_d, rbest_q, rbest_d, acc_q, acc_d, prod_q, prod_d;
  dword_t opa_q, opa_d, opb_q, opb_d;
  iter_op_e  op_q, op_d;
  logic      out_vld_q, out_vld_d;
  out_word_t out_q, out_d;

  // Shared unit and memory hookup.
  iter_req_t             req;
  logic                  it_done;
  dword_t                it_res;
  logic                  ld_we, bb_we;
  logic [AW-1:0]         bb_waddr, rd_addr, pf_addr;
  logic [31:0]           bb_wdata, bb_rdata;
  logic signed [31:0]    cv_rdata;
  logic signed [PFW-1:0] pf_rdata, pf_new;

  // Common combinational terms.
  logic              in_acc, out_acc, room, last_i, in_arc, split_last, p1_last;
  logic [AW-1:0]     pv2;
  dword_t            shift, tsum, tr16, cost, jval, xsel, dclamp, lam_e;
  logic [31:0]       t_comb;
  logic [CW-1:0]     neq_tot;
  logic [31+CW:0]    lam_cnt;
  logic              e1, e2;
  logic signed [CW:0] n1s, n2s;

  function automatic dword_t zx(input logic [31:0] v);
    return dword_t'({32'b0, v});
  endfunction

  assign in_acc     = in_valid_i && (state_q == S_LOAD);
  assign out_acc    = out_vld_q && !out_stall_i;
  assign room       = (cnt_q < CW'(MAX_POINTS));
  assign last_i     = (CW'(i_q) == cnt_q - CW'(1));
  assign in_arc     = (i_q >= p2_q) && (i_q < p1_q);
  assign pv2        = (p2_q == '0) ? AW'(cnt_q - CW'(1)) : p2_q - AW'(1);
  assign split_last = (p2_q + AW'(1) == p1_q);
  assign p1_last    = (CW'(p1_q) + CW'(1) == cnt_q);
  assign pf_new     = run_q + PFW'(in_data_i.curvature);
  assign n1s        = $signed({1'b0, n1_q});
  assign n2s        = $signed({1'b0, n2_q});

  // Trial beta of the point being read: shifted, then saturated to 32 bits.
  assign shift  = in_arc ? -dn2_q : dn1_q;
  assign tsum   = zx(bb_rdata) + shift;
  assign t_comb = tsum[DW-1] ? 32'd0 : ((tsum > zx(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                   : tsum[31:0]);

  // Product term truncated toward zero.
  assign tr16    = (prod_q + (prod_q[DW-1] ? dword_t'(65535) : dword_t'(0))) >>> 16;
  assign neq_tot = neq_q + CW'(t0_q != tprev_q);
  assign lam_cnt = lambda_q * neq_tot;
  assign cost    = acc_q + dword_t'({{(DW-32-CW){1'b0}}, lam_cnt});

  assign e1    = (zx(b_p1_q) + xa_q) != (zx(b_p1m_q) - xb_q);
  assign e2    = (zx(b_p2_q) - xb_q) != (zx(b_pv2_q) + xa_q);
  assign lam_e = (e1 && e2) ? zx(lambda_q) <<< 1 : ((e1 || e2) ? zx(lambda_q) : '0);
  assign jval  = it_res + lam_e;

  always_comb begin
    case (k_q)
      2'd0:    xsel = cand0_q;
      2'd1:    xsel = cand1_q;
      2'd2:    xsel = lo_q;
      default: xsel = hi_q;
    endcase
  end

  assign dclamp = (((d_q < lo_q) ? lo_q : d_q) > hi_q) ? hi_q
                                                      : ((d_q < lo_q) ? lo_q : d_q);

  l0pps_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (opa_q),
    .b_i    (opb_q),
    .done_o (it_done),
    .res_o  (it_res)
  );

  l0pps_mem #(.MAX_POINTS(MAX_POINTS)) u_mem (
    .clk_i      (clk_i),
    .ld_we_i    (ld_we),
    .ld_addr_i  (cnt_q[AW-1:0]),
    .ld_curv_i  (in_data_i.curvature),
    .ld_pf_i    (pf_new),
    .bb_we_i    (bb_we),
    .bb_waddr_i (bb_waddr),
    .bb_wdata_i (bb_wdata),
    .rd_addr_i  (rd_addr),
    .pf_addr_i  (pf_addr),
    .bb_rdata_o (bb_rdata),
    .cv_rdata_o (cv_rdata),
    .pf_rdata_o (pf_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD:   if (in_acc && in_data_i.last_point) state_d = S_INIT;
      S_INIT:   state_d = S_CRD;
      S_CRD:    state_d = S_CT;
      S_CT:     state_d = S_CM;
      S_CM:     state_d = S_CA;
      S_CA:     state_d = last_i ? S_CEND : S_CRD;
      S_CEND:   state_d = (mode_q == COST_INIT) ? S_RSTART : S_NEXT;
      S_RSTART: begin
        if (rnd_q >= maxr_q) state_d = S_ORD;
        else if (cnt_q < CW'(2)) state_d = S_REND;
        else state_d = S_SPLIT;
      end
      S_SPLIT:  state_d = S_SP1;
      S_SP1:    state_d = S_SP2;
      S_SP2:    state_d = S_SP3;
      S_SP3:    state_d = S_SP4;
      S_SP4:    state_d = S_MRD;
      S_MRD:    state_d = S_MUP;
      S_MUP:    state_d = last_i ? S_LH1 : S_MRD;
      S_LH1:    state_d = S_LH2;
      S_LH2:    state_d = S_CAND0;
      S_CAND0, S_CAND1, S_SLP1, S_SLP2, S_KX, S_KY, S_KQ, S_CLAMP, S_DN1:
                state_d = S_CALL;
      S_SLP3:   state_d = S_KX;
      S_KJ:     state_d = (k_q == 2'd3) ? S_CLAMP : S_KX;
      S_DN2:    state_d = S_CRD;
      S_NEXT:   state_d = (split_last && p1_last) ? S_REND : S_SPLIT;
      S_REND:   state_d = (rbest_q < best_q) ? S_ARD : S_ORD;
      S_ARD:    state_d = S_AWR;
      S_AWR:    state_d = last_i ? S_RSTART : S_ARD;
      S_CALL:   state_d = S_WAIT;
      S_WAIT:   if (it_done) state_d = ret_q;
      S_ORD:    state_d = S_OVL;
      S_OVL:    state_d = S_OHOLD;
      S_OHOLD:  if (out_acc) state_d = out_q.last_out ? S_LOAD : S_ORD;
      default:  state_d = S_LOAD;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    ret_d = ret_q; mode_d = mode_q;
    lambda_d = lambda_q; maxv_d = maxv_q; maxr_d = maxr_q; rnd_d = rnd_q;
    cnt_d = cnt_q; run_d = run_q; n1_d = n1_q; n2_d = n2_q; neq_d = neq_q;
    pf1_d = pf1_q; r1_d = r1_q; r2_d = r2_q;
    p1_d = p1_q; p2_d = p2_q; rb_p1_d = rb_p1_q; rb_p2_d = rb_p2_q;
    i_d = i_q; k_d = k_q; nn_d = nn_q;
    b_p2_d = b_p2_q; b_pv2_d = b_pv2_q; b_p1m_d = b_p1m_q; b_p1_d = b_p1_q;
    min1_d = min1_q; max1_d = max1_q; min2_d = min2_q; max2_d = max2_q;
    t_d = t_q; t0_d = t0_q; tprev_d = tprev_q; cv_d = cv_q;
    pa_d = pa_q; pb_d = pb_q; pc_d = pc_q; pd_d = pd_q;
    lo_d = lo_q; hi_d = hi_q; cand0_d = cand0_q; cand1_d = cand1_q;
    q1_d = q1_q; slope_d = slope_q; x_d = x_q; xa_d = xa_q; xb_d = xb_q;
    jbest_d = jbest_q; d_d = d_q; dn1_d = dn1_q; dn2_d = dn2_q;
    rb_dn1_d = rb_dn1_q; rb_dn2_d = rb_dn2_q;
    best_d = best_q; rbest_d = rbest_q; acc_d = acc_q; prod_d = prod_q;
    opa_d = opa_q; opb_d = opb_q; op_d = op_q;
    out_vld_d = out_vld_q; out_d = out_q;
    req = '{start: 1'b0, op: op_q};
    ld_we = 1'b0; bb_we = 1'b0; bb_waddr = i_q; bb_wdata = t_comb;
    rd_addr = i_q; pf_addr = p1_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LAMBDA:     lambda_d = cfg_data_i;
        CFG_MAX_VALUE:  maxv_d   = cfg_data_i;
        CFG_MAX_ROUNDS: maxr_d   = cfg_data_i[15:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_LOAD: begin
        if (in_acc && room) begin
          ld_we    = 1'b1;
          bb_we    = 1'b1;
          bb_waddr = cnt_q[AW-1:0];
          bb_wdata = in_data_i.beta;
          cnt_d    = cnt_q + CW'(1);
          run_d    = pf_new;
        end
      end
      S_INIT: begin
        // Cost of the loaded ring: no shift applied.
        i_d = '0; acc_d = '0; neq_d = '0;
        p1_d = '0; p2_d = '0; dn1_d = '0; dn2_d = '0;
        mode_d = COST_INIT;
      end
      S_CRD: rd_addr = i_q;
      S_CT: begin
        t_d  = t_comb;
        cv_d = cv_rdata;
      end
      S_CM: begin
        prod_d = cv_q * $signed({1'b0, t_q});
        if (i_q == '0) t0_d = t_q;
        else neq_d = neq_q + CW'(t_q != tprev_q);
        tprev_d = t_q;
      end
      S_CA: begin
        acc_d = acc_q + tr16;
        if (!last_i) i_d = i_q + AW'(1);
      end
      S_CEND: begin
        if (mode_q == COST_INIT) begin
          best_d = cost;
          rnd_d  = '0;
        end else if (cost < rbest_q) begin
          rbest_d  = cost;
          rb_p1_d  = p1_q;
          rb_p2_d  = p2_q;
          rb_dn1_d = dn1_q;
          rb_dn2_d = dn2_q;
        end
      end
      S_RSTART: begin
        rbest_d = DWORD_MAX;
        p1_d    = AW'(1);
        p2_d    = '0;
        i_d     = '0;
      end
      S_SPLIT: begin
        n1_d    = cnt_q - CW'(p1_q) + CW'(p2_q);
        n2_d    = CW'(p1_q) - CW'(p2_q);
        rd_addr = p2_q;
        pf_addr = p1_q;
      end
      S_SP1: begin
        b_p2_d  = bb_rdata;
        pf1_d   = pf_rdata;
        rd_addr = pv2;
        pf_addr = p2_q;
      end
      S_SP2: begin
        b_pv2_d = bb_rdata;
        r2_d    = pf1_q - pf_rdata;
        rd_addr = p1_q - AW'(1);
      end
      S_SP3: begin
        b_p1m_d = bb_rdata;
        rd_addr = p1_q;
      end
      S_SP4: begin
        b_p1_d = bb_rdata;
        r1_d   = run_q - r2_q;
        min1_d = '1; max1_d = '0; min2_d = '1; max2_d = '0;
        i_d    = '0;
      end
      S_MRD: rd_addr = i_q;
      S_MUP: begin
        if (in_arc) begin
          if (bb_rdata < min2_q) min2_d = bb_rdata;
          if (bb_rdata > max2_q) max2_d = bb_rdata;
        end else begin
          if (bb_rdata < min1_q) min1_d = bb_rdata;
          if (bb_rdata > max1_q) max1_d = bb_rdata;
        end
        if (!last_i) i_d = i_q + AW'(1);
      end
      S_LH1: begin
        pa_d = n1s * $signed({1'b0, min1_q});
        pb_d = n2s * ($signed({1'b0, max2_q}) - $signed({1'b0, maxv_q}));
        pc_d = n1s * ($signed({1'b0, maxv_q}) - $signed({1'b0, max1_q}));
        pd_d = n2s * $signed({1'b0, min2_q});
        nn_d = n1_q * n2_q;
      end
      S_LH2: begin
        lo_d = (pb_q > -pa_q) ? pb_q : -pa_q;
        hi_d = (pd_q < pc_q) ? pd_q : pc_q;
      end
      S_CAND0: begin
        opa_d = $signed({1'b0, nn_q}) * ($signed({1'b0, b_p2_q}) - $signed({1'b0, b_pv2_q}));
        opb_d = dword_t'(cnt_q);
        op_d  = OP_DIV;
        ret_d = S_CAND1;
      end
      S_CAND1: begin
        cand0_d = it_res;
        opa_d = $signed({1'b0, nn_q}) * ($signed({1'b0, b_p1m_q}) - $signed({1'b0, b_p1_q}));
        opb_d = dword_t'(cnt_q);
        op_d  = OP_DIV;
        ret_d = S_SLP1;
      end
      S_SLP1: begin
        cand1_d = it_res;
        opa_d   = dword_t'(r1_q);
        opb_d   = dword_t'(n1_q);
        op_d    = OP_DIV;
        ret_d   = S_SLP2;
      end
      S_SLP2: begin
        q1_d  = it_res;
        opa_d = dword_t'(r2_q);
        opb_d = dword_t'(n2_q);
        op_d  = OP_DIV;
        ret_d = S_SLP3;
      end
      S_SLP3: begin
        slope_d = q1_q - it_res;
        k_d     = '0;
        jbest_d = DWORD_MAX;
        d_d     = '0;
      end
      S_KX: begin
        x_d   = xsel;
        opa_d = xsel;
        opb_d = dword_t'(n1_q);
        op_d  = OP_DIV;
        ret_d = S_KY;
      end
      S_KY: begin
        xa_d  = it_res;
        opa_d = x_q;
        opb_d = dword_t'(n2_q);
        op_d  = OP_DIV;
        ret_d = S_KQ;
      end
      S_KQ: begin
        xb_d  = it_res;
        opa_d = slope_q;
        opb_d = x_q;
        op_d  = OP_QMUL;
        ret_d = S_KJ;
      end
      S_KJ: begin
        // The first strictly lowest candidate wins.
        if (jval < jbest_q) begin
          jbest_d = jval;
          d_d     = x_q;
        end
        k_d = k_q + 2'd1;
      end
      S_CLAMP: begin
        d_d   = dclamp;
        opa_d = dclamp;
        opb_d = dword_t'(n1_q);
        op_d  = OP_DIV;
        ret_d = S_DN1;
      end
      S_DN1: begin
        dn1_d = it_res;
        opa_d = d_q;
        opb_d = dword_t'(n2_q);
        op_d  = OP_DIV;
        ret_d = S_DN2;
      end
      S_DN2: begin
        dn2_d  = it_res;
        i_d    = '0;
        acc_d  = '0;
        neq_d  = '0;
        mode_d = COST_TRIAL;
      end
      S_NEXT: begin
        if (split_last) begin
          p1_d = p1_q + AW'(1);
          p2_d = '0;
        end else begin
          p2_d = p2_q + AW'(1);
        end
      end
      S_REND: begin
        i_d = '0;
        if (rbest_q < best_q) begin
          // Keep the round's best split: replay its shift over the store.
          best_d = rbest_q;
          p1_d   = rb_p1_q;
          p2_d   = rb_p2_q;
          dn1_d  = rb_dn1_q;
          dn2_d  = rb_dn2_q;
        end
      end
      S_ARD: rd_addr = i_q;
      S_AWR: begin
        bb_we    = 1'b1;
        bb_waddr = i_q;
        bb_wdata = t_comb;
        if (last_i) begin
          rnd_d = rnd_q + 16'd1;
          i_d   = '0;
        end else begin
          i_d = i_q + AW'(1);
        end
      end
      S_CALL: req = '{start: 1'b1, op: op_q};
      S_WAIT: ;
      S_ORD:  rd_addr = i_q;
      S_OVL: begin
        out_vld_d         = 1'b1;
        out_d.beta_out    = bb_rdata;
        out_d.point_index = 6'(i_q);
        out_d.last_out    = last_i;
      end
      S_OHOLD: begin
        if (out_acc) begin
          out_vld_d = 1'b0;
          if (out_q.last_out) begin
            cnt_d = '0;
            run_d = '0;
          end else begin
            i_d = i_q + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      lambda_q  <= 32'd65536;
      maxv_q    <= 32'hFFFF_FFFF;
      maxr_q    <= 16'd16;
      cnt_q     <= '0;
      run_q     <= '0;
      rnd_q     <= '0;
      best_q    <= '0;
      rbest_q   <= DWORD_MAX;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      lambda_q  <= lambda_d;
      maxv_q    <= maxv_d;
      maxr_q    <= maxr_d;
      cnt_q     <= cnt_d;
      run_q     <= run_d;
      rnd_q     <= rnd_d;
      best_q    <= best_d;
      rbest_q   <= rbest_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; mode_q <= mode_d;
    n1_q <= n1_d; n2_q <= n2_d; neq_q <= neq_d;
    pf1_q <= pf1_d; r1_q <= r1_d; r2_q <= r2_d;
    p1_q <= p1_d; p2_q <= p2_d; rb_p1_q <= rb_p1_d; rb_p2_q <= rb_p2_d;
    i_q <= i_d; k_q <= k_d; nn_q <= nn_d;
    b_p2_q <= b_p2_d; b_pv2_q <= b_pv2_d; b_p1m_q <= b_p1m_d; b_p1_q <= b_p1_d;
    min1_q <= min1_d; max1_q <= max1_d; min2_q <= min2_d; max2_q <= max2_d;
    t_q <= t_d; t0_q <= t0_d; tprev_q <= tprev_d; cv_q <= cv_d;
    pa_q <= pa_d; pb_q <= pb_d; pc_q <= pc_d; pd_q <= pd_d;
    lo_q <= lo_d; hi_q <= hi_d; cand0_q <= cand0_d; cand1_q <= cand1_d;
    q1_q <= q1_d; slope_q <= slope_d; x_q <= x_d; xa_q <= xa_d; xb_q <= xb_d;
    jbest_q <= jbest_d; d_q <= d_d; dn1_q <= dn1_d; dn2_q <= dn2_d;
    rb_dn1_q <= rb_dn1_d; rb_dn2_q <= rb_dn2_d;
    acc_q <= acc_d; prod_q <= prod_d;
    opa_q <= opa_d; opb_q <= opb_d; op_q <= op_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/sv/l0pps_checker.sv =====
// Checker for the profile pair shift optimizer: watches the input, output and
// register ports, predicts every output word and compares it field by field.
// Depends on l0pps_pkg for the word types and register codes.
module l0pps_checker import l0pps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  localparam int NP = 64;

  longint curv[NP], prefix[NP], base[NP], round_best[NP], trial[NP];
  int     loaded;
  longint lam, maxv;
  int     maxr;
  out_word_t expected_betas[$];

  assign pending_o = expected_betas.size();

  // Truncated Q16.16 product, wrapping in 64 bits like the datapath does.
  function automatic longint qmul(longint a, longint b);
    bit neg;
    bit [63:0] ua, ub, lo, mid, hi, m;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    lo  = {32'd0, ua[31:0]} * {32'd0, ub[31:0]};
    mid = {32'd0, ua[63:32]} * {32'd0, ub[31:0]} + {32'd0, ua[31:0]} * {32'd0, ub[63:32]};
    hi  = {32'd0, ua[63:32]} * {32'd0, ub[63:32]};
    m   = (hi << 48) + (mid << 16) + (lo >> 16);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic longint ring_cost(input longint b[NP], input int n);
    longint acc, cnt;
    acc = 0;
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      acc += (curv[i] * b[i]) / 65536;
      cnt += (b[i] != b[(i == 0) ? n - 1 : i - 1]) ? 1 : 0;
    end
    return acc + lam * cnt;
  endfunction

  function automatic void optimize_ring(int n);
    longint best_cost, rb_cost, n1, n2, r1, r2, min1, max1, min2, max2;
    longint lo, hi, t, d, cost, slope, jbest, x, e, j, b;
    longint cand[4];
    int pv2;
    best_cost = ring_cost(base, n);
    for (int r = 0; r < maxr; r++) begin
      rb_cost = 64'sh7fff_ffff_ffff_ffff;
      for (int p1 = 1; p1 < n; p1++) begin
        for (int p2 = 0; p2 < p1; p2++) begin
          n1 = n - p1 + p2;
          n2 = p1 - p2;
          r2 = prefix[p1] - prefix[p2];
          r1 = prefix[n-1] - r2;
          min1 = 64'sh7fff_ffff_ffff_ffff; min2 = min1; max1 = 0; max2 = 0;
          pv2 = (p2 == 0) ? n - 1 : p2 - 1;
          for (int i = 0; i < n; i++) begin
            if (i >= p2 && i < p1) begin
              if (base[i] < min2) min2 = base[i];
              if (base[i] > max2) max2 = base[i];
            end else begin
              if (base[i] < min1) min1 = base[i];
              if (base[i] > max1) max1 = base[i];
            end
          end
          lo = -n1 * min1;
          t = n2 * (max2 - maxv);
          if (t > lo) lo = t;
          hi = n1 * (maxv - max1);
          t = n2 * min2;
          if (t < hi) hi = t;
          cand[0] = (n1 * n2 * (base[p2] - base[pv2])) / n;
          cand[1] = (n1 * n2 * (base[p1-1] - base[p1])) / n;
          cand[2] = lo;
          cand[3] = hi;
          slope = r1 / n1 - r2 / n2;
          jbest = 64'sh7fff_ffff_ffff_ffff;
          d = 0;
          for (int k = 0; k < 4; k++) begin
            x = cand[k];
            e = ((base[p1] + x / n1) != (base[p1-1] - x / n2)) ? 1 : 0;
            e += ((base[p2] - x / n2) != (base[pv2] + x / n1)) ? 1 : 0;
            j = qmul(slope, x) + lam * e;
            if (j < jbest) begin
              jbest = j;
              d = x;
            end
          end
          if (d < lo) d = lo;
          if (d > hi) d = hi;
          for (int i = 0; i < n; i++) begin
            b = base[i] + ((i >= p2 && i < p1) ? -(d / n2) : d / n1);
            if (b < 0) b = 0;
            if (b > 64'sh0_ffff_ffff) b = 64'sh0_ffff_ffff;
            trial[i] = b;
          end
          cost = ring_cost(trial, n);
          if (cost < rb_cost) begin
            rb_cost = cost;
            round_best = trial;
          end
        end
      end
      if (rb_cost < best_cost) begin
        best_cost = rb_cost;
        base = round_best;
      end else begin
        break;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t w;
    if (!rst_ni) begin
      lam = 65536;
      maxv = 64'sh0_ffff_ffff;
      maxr = 16;
      loaded = 0;
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LAMBDA:     lam = {32'd0, cfg_data_i};
          CFG_MAX_VALUE:  maxv = {32'd0, cfg_data_i};
          CFG_MAX_ROUNDS: maxr = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (loaded < NP) begin
          curv[loaded] = longint'(in_data_i.curvature);
          prefix[loaded] = (loaded == 0) ? curv[0] : prefix[loaded-1] + curv[loaded];
          base[loaded] = {32'd0, in_data_i.beta};
          loaded++;
        end
        if (in_data_i.last_point) begin
          optimize_ring(loaded);
          for (int i = 0; i < loaded; i++) begin
            w.beta_out = base[i][31:0];
            w.point_index = i[5:0];
            w.last_out = (i == loaded - 1);
            expected_betas.push_back(w);
          end
          loaded = 0;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_betas.size() == 0) begin
          $error("unexpected output word: beta_out %h", out_data_i.beta_out);
          errors_o++;
        end else begin
          w = expected_betas.pop_front();
          if (w.beta_out !== out_data_i.beta_out) begin
            $error("beta_out expected %h actual %h", w.beta_out, out_data_i.beta_out);
            errors_o++;
          end
          if (w.point_index !== out_data_i.point_index) begin
            $error("point_index expected %0d actual %0d", w.point_index,
                   out_data_i.point_index);
            errors_o++;
          end
          if (w.last_out !== out_data_i.last_out) begin
            $error("last_out expected %b actual %b", w.last_out, out_data_i.last_out);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the optimizer testbench: clock, reset, register writes and ring
// stimulus, with random stalls on the output. Depends on l0pps_pkg, the
// optimizer RTL and l0pps_checker.
module testbench;
  import l0pps_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_LAMBDA;
  logic [31:0] cfg_data = '0;
  int          errors, pending, items, cycle_cnt;

  l0_profile_pair_shift_optimizer dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  l0pps_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver stalls at random, except in one long quiet stretch.
  always @(negedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    out_stall <= (cycle_cnt > 20000 && cycle_cnt < 120000) ? 1'b0
                 : ($urandom_range(99) < 17);
  end

  initial begin
    #400_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Each word goes out at a falling edge and is held until taken.
  task automatic send_point(logic [31:0] curv, logic [31:0] beta, logic last);
    if (!(cycle_cnt > 20000 && cycle_cnt < 120000)) begin
      while ($urandom_range(99) < 17) begin
        in_valid = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid = 1'b1;
    in_data.curvature = curv;
    in_data.beta = beta;
    in_data.last_point = last;
    forever begin
      @(posedge clk_i);
      if (!in_stall) break;
    end
    @(negedge clk_i);
    in_valid = 1'b0;
    items++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_value(logic [31:0] prev);
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return prev;
      3: return $urandom_range(32'h4_0000);
      4: return prev + $urandom_range(32'h2_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_ring(int n);
    logic [31:0] b, c;
    b = $urandom;
    c = $urandom;
    for (int i = 0; i < n; i++) begin
      b = rand_value(b);
      c = ($urandom_range(2) == 0) ? $urandom : rand_value(c);
      send_point(c, b, i == n - 1);
    end
  endtask

  initial begin
    int rounds, top;
    items = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset settings.
    send_point(32'h0, 32'h1234_0000, 1'b1);          // ring of one point
    send_point(32'h8000_0000, 32'h0, 1'b0);
    send_point(32'h7fff_ffff, 32'hffff_ffff, 1'b0);
    send_point(32'h0001_0000, 32'h0008_0000, 1'b1);
    for (int i = 0; i < 4; i++) send_point(32'hffff_0000, 32'h0002_0000, i == 3);
    drain();

    // Ring overflow with no rounds: the stored points come back unchanged.
    write_reg(CFG_MAX_ROUNDS, 32'd0);
    for (int i = 0; i < 66; i++) send_point($urandom, $urandom, i == 65);
    drain();

    // Largest round count on rings that settle at once.
    write_reg(CFG_MAX_ROUNDS, 32'h0000_ffff);
    send_point($urandom, $urandom, 1'b1);
    send_point(32'h0, 32'h5_0000, 1'b0);
    send_point(32'h0, 32'h5_0000, 1'b1);
    drain();

    // Zero weight and zero bound, then an inverted window.
    write_reg(CFG_LAMBDA, 32'h0);
    write_reg(CFG_MAX_VALUE, 32'h0);
    write_reg(CFG_MAX_ROUNDS, 32'd3);
    send_ring(3);
    drain();
    write_reg(CFG_LAMBDA, 32'hffff_ffff);
    write_reg(CFG_MAX_VALUE, 32'h0001_0000);
    send_point(32'h0001_0000, 32'h8000_0000, 1'b0);
    send_point(32'hfff0_0000, 32'h0000_8000, 1'b0);
    send_point(32'h0003_0000, 32'hffff_ffff, 1'b1);
    drain();

    // Random phases, each with its own settings.
    while (items < 440) begin
      case ($urandom_range(3))
        0: write_reg(CFG_LAMBDA, 32'h0);
        1: write_reg(CFG_LAMBDA, 32'hffff_ffff);
        2: write_reg(CFG_LAMBDA, $urandom_range(32'h4_0000));
        default: write_reg(CFG_LAMBDA, $urandom);
      endcase
      case ($urandom_range(3))
        0: write_reg(CFG_MAX_VALUE, 32'h0);
        1, 2: write_reg(CFG_MAX_VALUE, 32'hffff_ffff);
        default: write_reg(CFG_MAX_VALUE, $urandom);
      endcase
      rounds = ($urandom_range(7) == 0) ? 16 : $urandom_range(4);
      write_reg(CFG_MAX_ROUNDS, rounds);
      top = (rounds > 4) ? 3 : 5;
      for (int r = 0; r < 8; r++) send_ring($urandom_range(top, 1));
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/l0pps_pkg.sv
src/l0pps_iter.sv
src/l0pps_mem.sv
src/l0_profile_pair_shift_optimizer.sv
tb/sv/l0pps_checker.sv
tb/sv/testbench.sv
